@@ hdl/lcdseq_pkg.sv @@
// Shared types, constants and lookup functions for the character LCD
// nibble sequencer. No dependencies; imported by every module in hdl/.
`timescale 1ns / 1ps

package lcdseq_pkg;

  // Display geometry
  localparam int COLUMNS = 20;

  // Item kinds carried on the input tuser bit
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_CHAR  = 1'b1
  } item_kind_t;

  // Text bytes with special meaning
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_N   = 8'h6E;

  // Wait times in microseconds
  localparam logic [12:0] WAIT_NONE  = 13'd0;
  localparam logic [12:0] WAIT_PULSE = 13'd1;
  localparam logic [12:0] WAIT_SHORT = 13'd100;
  localparam logic [12:0] WAIT_CMD   = 13'd2000;
  localparam logic [12:0] WAIT_RESET = 13'd5000;

  // Power-up sequence: idle byte, 4 reset/init nibbles, 4 commands
  localparam int INIT_LEN = 25;
  localparam logic [7:0] IDLE_BYTE = 8'hF9;
  localparam logic [3:0] NIB_RESET = 4'h3;
  localparam logic [3:0] NIB_4BIT  = 4'h2;

  // Byte operation queued by the front end: RS flag plus 8-bit code
  typedef struct packed {
    logic       rs;
    logic [7:0] code;
  } op_t;

  // Work for one input item: the init run, or up to three byte ops
  typedef struct packed {
    logic            init;
    logic [1:0]      count;
    op_t [2:0]       ops;
  } job_t;

  // Text position state
  typedef struct packed {
    logic [2:0] row;
    logic [4:0] column;
    logic       held;
    logic       full;
  } lcd_state_t;

  // Set-DDRAM-address commands for rows 0..3
  function automatic logic [7:0] row_cmd(input logic [1:0] r);
    logic [7:0] v;
    case (r)
      2'd0:    v = 8'h80;
      2'd1:    v = 8'h80 | 8'h40;
      2'd2:    v = 8'h80 | 8'h14;
      default: v = 8'h80 | 8'h54;
    endcase
    return v;
  endfunction

  // Configuration commands sent after the 4-bit switch
  function automatic logic [7:0] cfg_cmd(input logic [1:0] k);
    logic [7:0] v;
    case (k)
      2'd0:    v = 8'b00101100;
      2'd1:    v = 8'b00001100;
      2'd2:    v = 8'b00000001;
      default: v = 8'b00000110;
    endcase
    return v;
  endfunction

  // Expander byte: data nibble high, backlight on, E, RW low, RS
  function automatic logic [7:0] nib_byte(input logic [3:0] nib, input logic rs,
                                          input logic en);
    return {nib, 1'b1, en, 1'b0, rs};
  endfunction

endpackage

@@ hdl/lcdseq_front.sv @@
// Front end: accepts items, tracks row/column/backslash state and turns
// each item that yields work into a job for the queue. Depends on lcdseq_pkg.
`timescale 1ns / 1ps

module lcdseq_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_kind,
  input  logic [7:0]          in_char,
  input  logic                in_last,
  input  logic                q_full,
  output logic                push,
  output lcdseq_pkg::job_t    push_job
);
  import lcdseq_pkg::*;

  typedef struct packed {
    lcd_state_t st;
    job_t       job;
  } place_t;

  lcd_state_t st;
  place_t     res;

  // Append one byte op to a job
  function automatic job_t add_op(input job_t j, input logic rs, input logic [7:0] code);
    job_t o;
    o = j;
    case (j.count)
      2'd0:    o.ops[0] = '{rs: rs, code: code};
      2'd1:    o.ops[1] = '{rs: rs, code: code};
      default: o.ops[2] = '{rs: rs, code: code};
    endcase
    o.count = j.count + 2'd1;
    return o;
  endfunction

  // Write one character, wrapping or moving rows as needed
  function automatic place_t place_char(input place_t p, input logic [7:0] c,
                                        input logic pair_nl);
    place_t     q;
    logic       nl;
    logic       wrap;
    logic [2:0] r;
    q    = p;
    nl   = pair_nl || (c == CH_LF);
    wrap = p.st.column >= 5'(COLUMNS);
    r    = p.st.row + 3'd1 + {2'b00, wrap && nl};
    if (!p.st.full) begin
      if (wrap || nl) begin
        if (r > 3'd3) begin
          q.st.full = 1'b1;
          q.st.held = 1'b0;
        end else begin
          q.job       = add_op(q.job, 1'b0, row_cmd(r[1:0]));
          q.st.row    = r;
          q.st.column = 5'd0;
          if (!nl) begin
            q.job       = add_op(q.job, 1'b1, c);
            q.st.column = 5'd1;
          end
        end
      end else begin
        q.job       = add_op(q.job, 1'b1, c);
        q.st.column = p.st.column + 5'd1;
      end
    end
    return q;
  endfunction

  // A backslash that is not last is held for pairing
  function automatic place_t take_char(input place_t p, input logic [7:0] c,
                                       input logic last);
    place_t q;
    q = p;
    if (c == CH_BSL && !last) begin
      q.st.held = 1'b1;
    end else begin
      q = place_char(p, c, 1'b0);
    end
    return q;
  endfunction

  // Whole item: start or character
  function automatic place_t step_item(input lcd_state_t s, input logic kind,
                                       input logic [7:0] c, input logic last);
    place_t p;
    p.st  = s;
    p.job = '0;
    if (kind == CMD_START) begin
      p.st       = '0;
      p.job.init = 1'b1;
    end else if (!s.full) begin
      if (s.held) begin
        p.st.held = 1'b0;
        if (c == CH_N) begin
          p = place_char(p, CH_BSL, 1'b1);
        end else begin
          p = place_char(p, CH_BSL, 1'b0);
          if (!p.st.full) begin
            p = take_char(p, c, last);
          end
        end
      end else begin
        p = take_char(p, c, last);
      end
    end
    return p;
  endfunction

  // Classify the offered item
  always_comb begin
    res      = step_item(st, in_kind, in_char, in_last);
    in_ready = !q_full;
    push     = in_valid && !q_full && (res.job.init || (res.job.count != 2'd0));
    push_job = res.job;
  end

  // Position state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (in_valid && in_ready) begin
      st <= res.st;
    end
  end

endmodule

@@ hdl/lcdseq_queue.sv @@
// Short job queue between front and back ends.
// Depends on lcdseq_pkg for the job type.
`timescale 1ns / 1ps

module lcdseq_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lcdseq_pkg::job_t    push_job,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output lcdseq_pkg::job_t    head_job
);
  import lcdseq_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  job_t        mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full       = count == (AW + 1)'(DEPTH);
  assign head_valid = count != '0;
  assign head_job   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/lcdseq_back.sv @@
// Back end: expands queued jobs into expander bytes with wait times,
// one byte per cycle, unless out_ready stalls it, into an output register. Depends on lcdseq_pkg.
`timescale 1ns / 1ps

module lcdseq_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  lcdseq_pkg::job_t    head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic [12:0]         out_wait,
  output logic                out_last
);
  import lcdseq_pkg::*;

  logic [4:0]  idx;
  logic [7:0]  gen_byte;
  logic [12:0] gen_wait;
  logic        gen_last;
  logic        load;
  op_t         cur_op;
  logic [4:0]  cfg_idx;
  logic [7:0]  cfg_code;
  logic [3:0]  nib;
  logic [3:0]  init_nib;

  // Byte generator for the current step
  always_comb begin
    cfg_idx  = idx - 5'd9;
    cfg_code = cfg_cmd(cfg_idx[3:2]);
    init_nib = (idx < 5'd7) ? NIB_RESET : NIB_4BIT;
    case (idx[3:2])
      2'd0:    cur_op = head_job.ops[0];
      2'd1:    cur_op = head_job.ops[1];
      default: cur_op = head_job.ops[2];
    endcase
    nib      = idx[1] ? cur_op.code[3:0] : cur_op.code[7:4];
    gen_byte = '0;
    gen_wait = WAIT_NONE;
    gen_last = 1'b0;
    if (head_job.init) begin
      gen_last = idx == 5'(INIT_LEN - 1);
      if (idx == 5'd0) begin
        gen_byte = IDLE_BYTE;
      end else if (idx < 5'd9) begin
        // reset and 4-bit switch nibbles: odd steps raise E
        gen_byte = nib_byte(init_nib, 1'b0, idx[0]);
        if (idx[0]) begin
          gen_wait = WAIT_PULSE;
        end else begin
          gen_wait = (idx < 5'd7) ? WAIT_RESET : WAIT_SHORT;
        end
      end else begin
        // configuration commands, two nibbles each
        gen_byte = nib_byte(cfg_idx[1] ? cfg_code[3:0] : cfg_code[7:4],
                            1'b0, !cfg_idx[0]);
        if (!cfg_idx[0]) begin
          gen_wait = WAIT_PULSE;
        end else if (cfg_idx[1]) begin
          gen_wait = WAIT_CMD;
        end
      end
    end else begin
      // text or row command: E high then E low per nibble
      gen_byte = nib_byte(nib, cur_op.rs, !idx[0]);
      gen_wait = idx[0] ? WAIT_NONE : WAIT_PULSE;
      gen_last = (idx[3:2] == head_job.count - 2'd1) && (idx[1:0] == 2'b11);
    end
    load = !out_valid || out_ready;
    pop  = load && head_valid && gen_last;
  end

  // Step counter within the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load && head_valid) begin
      idx <= gen_last ? 5'd0 : idx + 5'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      out_byte <= gen_byte;
      out_wait <= gen_wait;
      out_last <= gen_last;
    end
  end

endmodule

@@ hdl/char_lcd_text_nibble_sequencer.sv @@
// Character LCD nibble sequencer, top level. Front end, job queue, back end.
// Accepted items pass through the job queue and the back end's output register.
// Throughput: one item per cycle while the 4-deep queue has room; the back end emits
// one port byte per cycle unless stalled: 25 for a start, up to 12 for a character.
// Reset (rst, synchronous): position cleared, queue and output emptied.
`timescale 1ns / 1ps

module char_lcd_text_nibble_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] command
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] port_byte, [20:8] wait_us, [23:21] zero
  output logic        m_axis_tlast    // last_of_run
);
  import lcdseq_pkg::*;

  logic        q_full;
  logic        push;
  job_t        push_job;
  logic        pop;
  logic        head_valid;
  job_t        head_job;
  logic [7:0]  out_byte;
  logic [12:0] out_wait;

  // Item classification and position tracking
  lcdseq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_kind  (s_axis_tuser),
    .in_char  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // Decoupling queue
  lcdseq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Byte serializer
  lcdseq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (out_byte),
    .out_wait   (out_wait),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_wait, out_byte};

endmodule

@@ test/char_lcd_text_nibble_sequencer_test.sv @@
// Testbench for char_lcd_text_nibble_sequencer: drives text and start requests,
// predicts every expander port byte with its wait, and checks the output stream.
// Depends on hdl/lcdseq_pkg.sv and hdl/char_lcd_text_nibble_sequencer.sv.
`timescale 1ns / 1ps

module char_lcd_text_nibble_sequencer_test;
  import lcdseq_pkg::*;

  // One text request as offered on the input stream
  typedef struct packed {
    item_kind_t kind;
    logic [7:0] code;
    logic       last;
  } text_req_t;

  // One expected port byte on the output stream
  typedef struct packed {
    logic [7:0]  port;
    logic [12:0] wait_us;
    logic        last;
  } port_out_t;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 35;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;

  char_lcd_text_nibble_sequencer dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  text_req_t reqs_pending[$];
  port_out_t port_bytes_due[$];
  int        queued_cnt = 0;
  int        fail_cnt = 0;
  int        send_idle_pct = 0;
  int        take_idle_pct = 0;
  int        hold_asks = 0;
  logic      req_taken = 1'b0;

  // Display position tracked by the predictor
  logic [2:0] pos_row;
  logic [4:0] pos_col;
  logic       bsl_held;
  logic       text_done;

  logic [7:0] row_addr[4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};
  logic [7:0] setup_cmds[4] = '{8'h2C, 8'h0C, 8'h01, 8'h06};

  // ---------------------------------------------------------------
  // Port byte predictor
  // ---------------------------------------------------------------
  task automatic emit_byte(input logic [7:0] b, input logic [12:0] w);
    port_out_t o;
    o.port = b;
    o.wait_us = w;
    o.last = 1'b0;
    port_bytes_due.push_back(o);
  endtask

  // Enable pulse high, then low; backlight always on, RW low
  task automatic emit_nibble(input logic [3:0] nib, input logic rs, input logic [12:0] w);
    logic [7:0] pins;
    pins = {nib, 1'b1, 1'b0, 1'b0, rs};
    emit_byte(pins | 8'h04, WAIT_PULSE);
    emit_byte(pins, w);
  endtask

  task automatic emit_code(input logic [7:0] b, input logic rs, input logic [12:0] w);
    emit_nibble(b[7:4], rs, WAIT_NONE);
    emit_nibble(b[3:0], rs, w);
  endtask

  task automatic place_glyph(input logic [7:0] c, input logic pair_nl);
    logic nl;
    int   r;
    nl = pair_nl || (c == CH_LF);
    if (text_done) return;
    if (pos_col >= COLUMNS || nl) begin
      r = pos_row + 1;
      // a newline on a full row also skips the row the wrap would land on
      if (pos_col >= COLUMNS && nl) r++;
      if (r > 3) begin
        text_done = 1'b1;
        bsl_held = 1'b0;
        return;
      end
      emit_code(row_addr[2'(r)], 1'b0, WAIT_NONE);
      pos_row = 3'(r);
      pos_col = '0;
      if (nl) return;
    end
    emit_code(c, 1'b1, WAIT_NONE);
    pos_col++;
  endtask

  task automatic take_glyph(input logic [7:0] c, input logic last);
    if (c == CH_BSL && !last) begin
      bsl_held = 1'b1;
      return;
    end
    place_glyph(c, 1'b0);
  endtask

  task automatic forecast_port_bytes(input item_kind_t kind, input logic [7:0] c,
                                     input logic last);
    int        due_before;
    port_out_t tail;
    due_before = port_bytes_due.size();
    if (kind == CMD_START) begin
      pos_row = '0;
      pos_col = '0;
      bsl_held = 1'b0;
      text_done = 1'b0;
      emit_byte(IDLE_BYTE, WAIT_NONE);
      repeat (3) emit_nibble(NIB_RESET, 1'b0, WAIT_RESET);
      emit_nibble(NIB_4BIT, 1'b0, WAIT_SHORT);
      for (int i = 0; i < 4; i++) emit_code(setup_cmds[i], 1'b0, WAIT_CMD);
    end else if (!text_done) begin
      if (bsl_held) begin
        bsl_held = 1'b0;
        if (c == CH_N) begin
          place_glyph(CH_BSL, 1'b1);
        end else begin
          place_glyph(CH_BSL, 1'b0);
          if (!text_done) take_glyph(c, last);
        end
      end else begin
        take_glyph(c, last);
      end
    end
    // flag the final byte of this request
    if (port_bytes_due.size() > due_before) begin
      tail = port_bytes_due.pop_back();
      tail.last = 1'b1;
      port_bytes_due.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  task automatic push_req(input item_kind_t kind, input logic [7:0] c, input logic last);
    text_req_t q;
    q.kind = kind;
    q.code = c;
    q.last = last;
    reqs_pending.push_back(q);
    queued_cnt++;
  endtask

  // Mostly printable text, some raw bytes
  function automatic logic [7:0] pick_glyph();
    if ($urandom_range(99) < 85) return 8'($urandom_range(8'h20, 8'h7E));
    return 8'($urandom_range(0, 255));
  endfunction

  // A start followed by a few lines of text, each ended by a newline, a
  // backslash-n pair or nothing; enough lines at times to run past the last row
  task automatic queue_text_run();
    int lines;
    int len;
    int roll;
    push_req(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    lines = $urandom_range(1, 5);
    for (int i = 0; i < lines; i++) begin
      roll = $urandom_range(99);
      if (roll < 15) len = COLUMNS;
      else if (roll < 25) len = $urandom_range(COLUMNS + 1, COLUMNS + 2);
      else len = $urandom_range(0, 6);
      for (int k = 0; k < len; k++)
        push_req(CMD_CHAR, pick_glyph(), 1'($urandom_range(99) < 4));
      roll = $urandom_range(99);
      if (roll < 45) begin
        push_req(CMD_CHAR, CH_LF, 1'b0);
      end else if (roll < 85) begin
        push_req(CMD_CHAR, CH_BSL, 1'b0);
        push_req(CMD_CHAR, CH_N, 1'($urandom_range(0, 1)));
      end
    end
    push_req(CMD_CHAR, pick_glyph(), 1'b1);
    // occasionally keep typing after the final character
    if ($urandom_range(99) < 30)
      repeat ($urandom_range(1, 4))
        push_req(CMD_CHAR, pick_glyph(), 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------
  // Input driver: one request at a time, random gaps
  // ---------------------------------------------------------------
  always @(negedge clk) begin : driver
    text_req_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (reqs_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = reqs_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= nxt.kind;
        s_axis_tdata <= nxt.code;
        s_axis_tlast <= nxt.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // Output receiver: random stalls plus long hold-offs on request
  // ---------------------------------------------------------------
  int hold_left = 0;
  int hold_done = 0;

  always @(negedge clk) begin : receiver
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_asks != hold_done) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // ---------------------------------------------------------------
  // Monitor: predict on accepted requests, check accepted port bytes
  // ---------------------------------------------------------------
  always @(posedge clk) begin : monitor
    port_out_t want;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready)
        forecast_port_bytes(item_kind_t'(s_axis_tuser), s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (port_bytes_due.size() == 0) begin
          $error("unexpected port byte: port_byte=%h wait_us=%0d last_of_run=%b",
                 m_axis_tdata[7:0], m_axis_tdata[20:8], m_axis_tlast);
          fail_cnt++;
        end else begin
          want = port_bytes_due.pop_front();
          if (m_axis_tdata[7:0] !== want.port) begin
            $error("port_byte: expected %h, got %h", want.port, m_axis_tdata[7:0]);
            fail_cnt++;
          end
          if (m_axis_tdata[20:8] !== want.wait_us) begin
            $error("wait_us: expected %0d, got %0d", want.wait_us, m_axis_tdata[20:8]);
            fail_cnt++;
          end
          if (m_axis_tdata[23:21] !== 3'b000) begin
            $error("tdata pad: expected 0, got %b", m_axis_tdata[23:21]);
            fail_cnt++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_run: expected %b, got %b", want.last, m_axis_tlast);
            fail_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Watchdog: too long without any transfer on either side
  // ---------------------------------------------------------------
  int stall_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase 1: sender idles a little, receiver a lot
    send_idle_pct = 26;
    take_idle_pct = 62;

    // Directed: extremes, newline forms, held backslash cases, running full
    push_req(CMD_START, 8'h00, 1'b0);
    push_req(CMD_CHAR, 8'h41, 1'b0);
    push_req(CMD_CHAR, 8'h00, 1'b0);
    push_req(CMD_CHAR, 8'hFF, 1'b0);
    push_req(CMD_CHAR, CH_LF, 1'b0);
    push_req(CMD_CHAR, CH_BSL, 1'b0);   // held
    push_req(CMD_CHAR, CH_N, 1'b0);     // pair acts as newline
    push_req(CMD_CHAR, CH_BSL, 1'b0);
    push_req(CMD_CHAR, 8'h78, 1'b0);    // held backslash written, then 'x'
    push_req(CMD_CHAR, CH_BSL, 1'b0);
    push_req(CMD_CHAR, CH_BSL, 1'b0);   // first written, second held
    push_req(CMD_CHAR, CH_N, 1'b0);
    push_req(CMD_CHAR, CH_BSL, 1'b1);   // backslash as final char is plain
    push_req(CMD_CHAR, CH_N, 1'b0);
    push_req(CMD_CHAR, CH_BSL, 1'b0);
    push_req(CMD_START, 8'hFF, 1'b1);   // start drops the held backslash
    repeat (4) push_req(CMD_CHAR, CH_LF, 1'b0);  // last one runs off the display
    push_req(CMD_CHAR, 8'h5A, 1'b0);    // dropped
    push_req(CMD_CHAR, CH_BSL, 1'b0);   // dropped
    push_req(CMD_START, 8'h00, 1'b0);
    push_req(CMD_CHAR, 8'h51, 1'b1);
    push_req(CMD_CHAR, 8'h52, 1'b0);    // continues after the final char

    while (queued_cnt < 25 + RANDOM_PER_PHASE) queue_text_run();
    while (reqs_pending.size() != 0) @(posedge clk);

    // Phase 2: the other way round
    send_idle_pct = 62;
    take_idle_pct = 26;
    while (queued_cnt < 25 + 2 * RANDOM_PER_PHASE) queue_text_run();
    while (reqs_pending.size() != 0) @(posedge clk);

    // Phase 3: no idling, with a long receiver hold-off to back up the block
    send_idle_pct = 0;
    take_idle_pct = 0;
    hold_asks++;
    while (queued_cnt < 25 + 3 * RANDOM_PER_PHASE) queue_text_run();

    while (reqs_pending.size() != 0 || s_axis_tvalid || port_bytes_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/lcdseq_pkg.sv
hdl/lcdseq_front.sv
hdl/lcdseq_queue.sv
hdl/lcdseq_back.sv
hdl/char_lcd_text_nibble_sequencer.sv
test/char_lcd_text_nibble_sequencer_test.sv
